[src/sec_pkg.sv]
// shared types, constants and character classes for the shadow entry checker
// no dependencies
package sec_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COLON_W  = 4;
    localparam int unsigned DOLLAR_W = 3;
    localparam int unsigned HLEN_W   = 7;

    localparam logic [COLON_W-1:0]  COLON_MAX  = '1;
    localparam logic [DOLLAR_W-1:0] DOLLAR_MAX = '1;
    localparam logic [HLEN_W-1:0]   HLEN_MAX   = '1;

    localparam logic [COLON_W-1:0]  COLON_REQ   = COLON_W'(8);
    localparam logic [DOLLAR_W-1:0] DOLLAR_REQ  = DOLLAR_W'(3);
    localparam logic [HLEN_W-1:0]   HLEN_MD5    = HLEN_W'(22);
    localparam logic [HLEN_W-1:0]   HLEN_SHA512 = HLEN_W'(86);

    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3a;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_ONE    = 8'h31;
    localparam logic [BYTE_W-1:0] CH_SIX    = 8'h36;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5a;
    localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z   = 8'h7a;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;

    localparam logic KIND_MD5    = 1'b0;
    localparam logic KIND_SHA512 = 1'b1;

    typedef enum logic [2:0] {
        PH_BEFORE = 3'd0,
        PH_DIGIT  = 3'd1,
        PH_DOL2   = 3'd2,
        PH_DOL3   = 3'd3,
        PH_HASH   = 3'd4,
        PH_TAIL   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              line_end;
    } beat_t;

    typedef struct packed {
        logic line_valid;
        logic hash_kind;
    } verdict_t;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_hash_char(input logic [BYTE_W-1:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
               is_digit(c) || (c == CH_DOT) || (c == CH_SLASH);
    endfunction

    function automatic logic is_tail_char(input logic [BYTE_W-1:0] c);
        return is_digit(c) || (c == CH_COLON) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

[src/sec_in_reg.sv]
// input register of the checker: captures one byte beat from the slave side
// depends on sec_pkg
module sec_in_reg
    import sec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] line_byte
    input  logic              s_tlast,
    input  logic              advance,
    output logic              beat_valid,
    output beat_t             beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    // refill in the same cycle the held beat moves on
    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg <= '{line_byte: s_tdata, line_end: s_tlast};
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

[src/sec_scan.sv]
// line scanner: counters, scan phase and verdict; depends on sec_pkg
// one byte per cycle unless an end byte waits for the output register
module sec_scan
    import sec_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     beat_valid,
    input  beat_t    beat,
    input  logic     out_free,
    output logic     advance,
    output logic     res_valid,
    output verdict_t res
);

    logic [COLON_W-1:0]  colon_reg,  colon_next,  colon_upd;
    logic [DOLLAR_W-1:0] dollar_reg, dollar_next, dollar_upd;
    logic [HLEN_W-1:0]   hlen_reg,   hlen_next,   hlen_upd;
    phase_t              phase_reg,  phase_next,  phase_upd;
    logic                kind_reg,   kind_next,   kind_upd;
    logic                fault_reg,  fault_next,  fault_upd;
    logic [BYTE_W-1:0]   c;
    logic                ok;

    assign c = beat.line_byte;

    // a byte without end mark never needs the output register
    assign advance = beat_valid && (!beat.line_end || out_free);

    always_comb begin
        colon_upd  = colon_reg;
        dollar_upd = dollar_reg;
        hlen_upd   = hlen_reg;
        phase_upd  = phase_reg;
        kind_upd   = kind_reg;
        fault_upd  = fault_reg;
        if ((c == CH_COLON) && (colon_reg != COLON_MAX)) begin
            colon_upd = colon_reg + COLON_W'(1);
        end
        if ((c == CH_DOLLAR) && (dollar_reg != DOLLAR_MAX)) begin
            dollar_upd = dollar_reg + DOLLAR_W'(1);
        end
        unique case (phase_reg)
            PH_BEFORE: begin
                if (c == CH_DOLLAR) begin
                    phase_upd = PH_DIGIT;
                end
            end
            PH_DIGIT: begin
                if ((c == CH_ONE) || (c == CH_SIX)) begin
                    kind_upd  = (c == CH_SIX) ? KIND_SHA512 : KIND_MD5;
                    phase_upd = PH_DOL2;
                end else begin
                    fault_upd = 1'b1;
                end
            end
            PH_DOL2: begin
                if (c == CH_DOLLAR) begin
                    phase_upd = PH_DOL3;
                end else begin
                    fault_upd = 1'b1;
                end
            end
            PH_DOL3: begin
                if (c == CH_DOLLAR) begin
                    phase_upd = PH_HASH;
                end else begin
                    fault_upd = 1'b1;
                end
            end
            PH_HASH: begin
                priority if (c == CH_COLON) begin
                    if ((hlen_reg != HLEN_MD5) && (hlen_reg != HLEN_SHA512)) begin
                        fault_upd = 1'b1;
                    end
                    phase_upd = PH_TAIL;
                end else if (is_hash_char(c)) begin
                    if (hlen_reg != HLEN_MAX) begin
                        hlen_upd = hlen_reg + HLEN_W'(1);
                    end
                end else begin
                    fault_upd = 1'b1;
                end
            end
            PH_TAIL: begin
                if (!is_tail_char(c)) begin
                    fault_upd = 1'b1;
                end
            end
            default: begin
                fault_upd = 1'b1;
            end
        endcase
    end

    assign ok = !fault_upd && (colon_upd == COLON_REQ) && (dollar_upd == DOLLAR_REQ) &&
                (phase_upd == PH_TAIL);

    assign res_valid      = advance && beat.line_end;
    assign res.line_valid = ok;
    assign res.hash_kind  = ok && kind_upd;

    // state returns to its reset value once a line's verdict is out
    always_comb begin
        priority if (advance && beat.line_end) begin
            colon_next  = '0;
            dollar_next = '0;
            hlen_next   = '0;
            phase_next  = PH_BEFORE;
            kind_next   = 1'b0;
            fault_next  = 1'b0;
        end else if (advance) begin
            colon_next  = colon_upd;
            dollar_next = dollar_upd;
            hlen_next   = hlen_upd;
            phase_next  = phase_upd;
            kind_next   = kind_upd;
            fault_next  = fault_upd;
        end else begin
            colon_next  = colon_reg;
            dollar_next = dollar_reg;
            hlen_next   = hlen_reg;
            phase_next  = phase_reg;
            kind_next   = kind_reg;
            fault_next  = fault_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colon_reg  <= '0;
            dollar_reg <= '0;
            hlen_reg   <= '0;
            phase_reg  <= PH_BEFORE;
            kind_reg   <= 1'b0;
            fault_reg  <= 1'b0;
        end else begin
            colon_reg  <= colon_next;
            dollar_reg <= dollar_next;
            hlen_reg   <= hlen_next;
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            fault_reg  <= fault_next;
        end
    end

    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && beat.line_end) |=>
            (colon_reg == '0 && dollar_reg == '0 && hlen_reg == '0 &&
             phase_reg == PH_BEFORE && !fault_reg))
        else $error("scan state not cleared after line end");

    a_kind_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res.line_valid |-> !res.hash_kind)
        else $error("hash kind set on invalid line");

    a_hlen_only_in_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        (hlen_reg != '0) |-> (phase_reg == PH_HASH || phase_reg == PH_TAIL))
        else $error("hash length counted outside hash phase");

endmodule

[src/sec_out_reg.sv]
// output register: holds one verdict beat toward the master side
// depends on sec_pkg
module sec_out_reg
    import sec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  verdict_t          res,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [0] line_valid, [7:1] zero
    output logic              m_tuser    // [0] hash_kind
);

    logic     valid_reg;
    logic     valid_next;
    verdict_t res_reg;

    assign out_free   = !valid_reg || m_tready;
    assign valid_next = res_valid ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(BYTE_W-1){1'b0}}, res_reg.line_valid};
    assign m_tuser  = res_reg.hash_kind;

endmodule

[src/shadow_entry_checker_top.sv]
// m_tvalid for a line's verdict rises once its last byte has passed the input register and the output register
// throughput: one byte per cycle, including back-to-back lines
// s_tready drops only while the input register holds an end-of-line byte and the
// output register holds a verdict not yet taken
// reset: aresetn synchronous active low clears both registers' valid bits and the
// scan counters, phase and flags
module shadow_entry_checker_top
    import sec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] line_byte
    input  logic              s_tlast,   // line_end
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [0] line_valid, [7:1] zero
    output logic              m_tuser    // [0] hash_kind
);

    logic     beat_valid;
    beat_t    beat;
    logic     advance;
    logic     out_free;
    logic     res_valid;
    verdict_t res;

    sec_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    sec_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_valid),
        .beat       (beat),
        .out_free   (out_free),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    sec_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[bench/sec_verdict_checker.sv]
// line verdict checker: watches both stream channels of the shadow entry checker,
// predicts each line's verdict and compares it with the m_* beats
// depends on sec_pkg for widths, character constants, phase_t and verdict_t
module sec_verdict_checker
    import sec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [BYTE_W-1:0] m_tdata,
    input  logic              m_tuser,
    input  logic              run_done,
    output int                fail_count,
    output int                verdicts_pending,
    output int                verdicts_checked,
    output int                valid_verdicts
);

    logic [COLON_W-1:0]  colons_seen;
    logic [DOLLAR_W-1:0] dollars_seen;
    logic [HLEN_W-1:0]   hash_run;
    phase_t              cur_phase;
    logic                sha_prefix;
    logic                line_broken;

    verdict_t expected_verdicts[$];

    int  mismatches   = 0;
    int  checked      = 0;
    int  valid_count  = 0;
    bit  tail_checked = 1'b0;

    initial begin
        fail_count       = 0;
        verdicts_pending = 0;
        verdicts_checked = 0;
        valid_verdicts   = 0;
    end

    function automatic logic hash_symbol(input logic [BYTE_W-1:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
               (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_SLASH;
    endfunction

    function automatic logic tail_symbol(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || c == CH_COLON || c == CH_LF || c == CH_CR;
    endfunction

    task automatic clear_scan();
        colons_seen  = '0;
        dollars_seen = '0;
        hash_run     = '0;
        cur_phase    = PH_BEFORE;
        sha_prefix   = 1'b0;
        line_broken  = 1'b0;
    endtask

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // one accepted input beat: update the line scan, queue a verdict on end of line
    task automatic scan_beat(input logic [BYTE_W-1:0] c, input logic last);
        verdict_t v;
        logic     ok;
        if (c == CH_COLON && colons_seen != COLON_MAX)
            colons_seen++;
        if (c == CH_DOLLAR && dollars_seen != DOLLAR_MAX)
            dollars_seen++;
        case (cur_phase)
            PH_BEFORE: begin
                if (c == CH_DOLLAR)
                    cur_phase = PH_DIGIT;
            end
            PH_DIGIT: begin
                if (c == CH_ONE || c == CH_SIX) begin
                    sha_prefix = (c == CH_SIX) ? KIND_SHA512 : KIND_MD5;
                    cur_phase  = PH_DOL2;
                end else begin
                    line_broken = 1'b1;
                end
            end
            PH_DOL2: begin
                if (c == CH_DOLLAR)
                    cur_phase = PH_DOL3;
                else
                    line_broken = 1'b1;
            end
            PH_DOL3: begin
                if (c == CH_DOLLAR)
                    cur_phase = PH_HASH;
                else
                    line_broken = 1'b1;
            end
            PH_HASH: begin
                if (c == CH_COLON) begin
                    if (hash_run != HLEN_MD5 && hash_run != HLEN_SHA512)
                        line_broken = 1'b1;
                    cur_phase = PH_TAIL;
                end else if (hash_symbol(c)) begin
                    if (hash_run != HLEN_MAX)
                        hash_run++;
                end else begin
                    line_broken = 1'b1;
                end
            end
            PH_TAIL: begin
                if (!tail_symbol(c))
                    line_broken = 1'b1;
            end
            default: line_broken = 1'b1;
        endcase
        if (last) begin
            ok = !line_broken && colons_seen == COLON_REQ && dollars_seen == DOLLAR_REQ &&
                 cur_phase == PH_TAIL;
            v.line_valid = ok;
            v.hash_kind  = ok & sha_prefix;
            expected_verdicts.push_back(v);
            clear_scan();
        end
    endtask

    always @(posedge aclk) begin
        verdict_t exp_v;
        if (!aresetn) begin
            clear_scan();
            expected_verdicts.delete();
        end else begin
            // a result leaves only after its beat has passed the input and output registers, so check before queuing
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    flag_mismatch($sformatf("verdict with no line pending, tdata %h tuser %b",
                                            m_tdata, m_tuser));
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    checked++;
                    if (exp_v.line_valid)
                        valid_count++;
                    if (m_tdata[0] !== exp_v.line_valid)
                        flag_mismatch($sformatf("line_valid %b, expected %b",
                                                m_tdata[0], exp_v.line_valid));
                    if (m_tdata[BYTE_W-1:1] !== '0)
                        flag_mismatch($sformatf("tdata padding %h not zero", m_tdata));
                    if (m_tuser !== exp_v.hash_kind)
                        flag_mismatch($sformatf("hash_kind %b, expected %b",
                                                m_tuser, exp_v.hash_kind));
                end
            end
            if (s_tvalid && s_tready)
                scan_beat(s_tdata, s_tlast);
            if (run_done && !tail_checked) begin
                tail_checked = 1'b1;
                if (expected_verdicts.size() != 0)
                    flag_mismatch($sformatf("%0d verdicts never arrived",
                                            expected_verdicts.size()));
            end
        end
        fail_count       <= mismatches;
        verdicts_pending <= expected_verdicts.size();
        verdicts_checked <= checked;
        valid_verdicts   <= valid_count;
    end

endmodule

[bench/tb.sv]
// top of the shadow entry checker bench: clock, reset, line stimulus with random
// idling on both channels, watchdog and final verdict
// depends on sec_pkg, shadow_entry_checker_top and sec_verdict_checker
module tb;
    import sec_pkg::*;

    localparam int IDLE_PCT    = 31;
    localparam int ITEM_TARGET = 1700;
    localparam int LINE_TARGET = 60;
    localparam int STALL_LIMIT = 2000;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tuser;
    logic              run_done = 1'b0;

    int fail_count;
    int verdicts_pending;
    int verdicts_checked;
    int valid_verdicts;

    bit calm        = 1'b0;
    int bytes_sent  = 0;
    int lines_sent  = 0;
    int quiet_count = 0;

    logic [BYTE_W-1:0] line_q[$];

    always #5 aclk = ~aclk;

    shadow_entry_checker_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sec_verdict_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .run_done         (run_done),
        .fail_count       (fail_count),
        .verdicts_pending (verdicts_pending),
        .verdicts_checked (verdicts_checked),
        .valid_verdicts   (valid_verdicts)
    );

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ends the run when neither channel moves a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    function automatic logic [BYTE_W-1:0] hash_symbol_at(input int idx);
        if (idx < 26)
            return BYTE_W'(CH_UP_A + idx);
        if (idx < 52)
            return BYTE_W'(CH_LO_A + idx - 26);
        if (idx < 62)
            return BYTE_W'(CH_ZERO + idx - 52);
        return (idx == 62) ? CH_DOT : CH_SLASH;
    endfunction

    function automatic logic [BYTE_W-1:0] any_digit();
        return BYTE_W'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] d, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_beat(line_q[i], i == line_q.size() - 1);
        lines_sent++;
    endtask

    task automatic load_text(input string s);
        line_q.delete();
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    // well-formed entries with random content for half the lines, the rest broken or noise
    task automatic build_line();
        int mode, name_len, hlen, tail_colons, extra_dollars, pos, keep;
        bit do_corrupt, do_trunc, bad_digit;
        logic [BYTE_W-1:0] b;
        line_q.delete();
        mode          = $urandom_range(0, 99);
        extra_dollars = 0;
        do_corrupt    = 1'b0;
        do_trunc      = 1'b0;
        bad_digit     = 1'b0;
        if (mode < 10) begin
            repeat ($urandom_range(1, 40)) begin
                case ($urandom_range(0, 7))
                    0:       line_q.push_back(CH_COLON);
                    1:       line_q.push_back(CH_DOLLAR);
                    default: line_q.push_back(BYTE_W'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        hlen        = ($urandom_range(0, 4) == 0) ? 86 : 22;
        tail_colons = 6;
        if (mode >= 60) begin
            case ($urandom_range(0, 6))
                0: begin
                    case ($urandom_range(0, 7))
                        0: hlen = 0;
                        1: hlen = 1;
                        2: hlen = 21;
                        3: hlen = 23;
                        4: hlen = 85;
                        5: hlen = 87;
                        6: hlen = 127;
                        default: hlen = 140;
                    endcase
                end
                1: tail_colons += $urandom_range(1, 10);
                2: tail_colons -= $urandom_range(1, 6);
                3: extra_dollars = $urandom_range(1, 6);
                4: do_corrupt = 1'b1;
                5: do_trunc = 1'b1;
                default: bad_digit = 1'b1;
            endcase
        end
        name_len = $urandom_range(0, 6);
        repeat (name_len) begin
            do
                b = BYTE_W'($urandom_range(0, 255));
            while (b == CH_COLON || b == CH_DOLLAR);
            line_q.push_back(b);
        end
        line_q.push_back(CH_COLON);
        line_q.push_back(CH_DOLLAR);
        if (bad_digit)
            line_q.push_back(BYTE_W'($urandom_range(0, 255)));
        else
            line_q.push_back($urandom_range(0, 1) ? CH_SIX : CH_ONE);
        line_q.push_back(CH_DOLLAR);
        line_q.push_back(CH_DOLLAR);
        repeat (hlen)
            line_q.push_back(hash_symbol_at($urandom_range(0, 63)));
        line_q.push_back(CH_COLON);
        repeat (tail_colons) begin
            repeat ($urandom_range(0, 3))
                line_q.push_back(any_digit());
            line_q.push_back(CH_COLON);
        end
        repeat ($urandom_range(0, 3))
            line_q.push_back(any_digit());
        case ($urandom_range(0, 3))
            1: line_q.push_back(CH_LF);
            2: begin
                line_q.push_back(CH_CR);
                line_q.push_back(CH_LF);
            end
            3: line_q.push_back(CH_CR);
            default: ;
        endcase
        repeat (extra_dollars) begin
            pos = $urandom_range(0, line_q.size());
            line_q.insert(pos, CH_DOLLAR);
        end
        if (do_corrupt) begin
            pos = $urandom_range(0, line_q.size() - 1);
            line_q[pos] = BYTE_W'($urandom_range(0, 255));
        end
        if (do_trunc) begin
            keep = $urandom_range(1, line_q.size() - 1);
            while (line_q.size() > keep)
                void'(line_q.pop_back());
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero and high bytes as whole lines, early ends, bad prefix,
        // empty hash, high byte inside the hash
        line_q = '{8'h00};
        send_line();
        line_q = '{8'hff};
        send_line();
        load_text("$");
        send_line();
        load_text("$2");
        send_line();
        load_text("$1$x");
        send_line();
        load_text("$6$$:");
        send_line();
        load_text("$6$$.");
        line_q.push_back(8'h80);
        send_line();

        while (bytes_sent < ITEM_TARGET || lines_sent < LINE_TARGET) begin
            calm = (lines_sent >= 25 && lines_sent < 40);
            build_line();
            send_line();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // the pending count is a registered copy, so it trails the last accepted beat
        @(posedge aclk);
        while (verdicts_pending != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        run_done <= 1'b1;
        repeat (3) @(posedge aclk);

        $display("sent %0d lines in %0d beats, random idling on both channels",
                 lines_sent, bytes_sent);
        $display("checked %0d verdicts, %0d valid entries among them",
                 verdicts_checked, valid_verdicts);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[shadow_entry_checker_top.f]
src/sec_pkg.sv
src/sec_in_reg.sv
src/sec_scan.sv
src/sec_out_reg.sv
src/shadow_entry_checker_top.sv
bench/sec_verdict_checker.sv
bench/tb.sv
